// File: hw/rtl/blt_pkg.sv
package blt_pkg;

    // default geometry
    localparam int DEF_ROW_WIDTH = 64;
    localparam int DEF_MAX_ROWS  = 64;

    // configuration register indexes
    localparam logic CFG_COLS_IN_USE = 1'b0;
    localparam logic CFG_MAX_PASSES  = 1'b1;

    // configuration reset values
    localparam logic [6:0] COLS_IN_USE_RST = 7'd64;
    localparam logic [5:0] MAX_PASSES_RST  = 6'd20;

    // result status codes
    localparam logic [1:0] STAT_CONVERGED  = 2'd0;
    localparam logic [1:0] STAT_PASS_LIMIT = 2'd1;
    localparam logic [1:0] STAT_EMPTY      = 2'd2;

    // hit/miss template pairs on the neighbour word
    // bits: 0 nw, 1 w, 2 sw, 3 s, 4 se, 5 e, 6 ne, 7 n
    localparam logic [7:0] HIT_TPL [8] = '{
        8'd40, 8'd10, 8'd130, 8'd160, 8'd42, 8'd138, 8'd162, 8'd168
    };
    localparam logic [7:0] MISS_TPL [8] = '{
        8'd131, 8'd224, 8'd56, 8'd14, 8'd128, 8'd32, 8'd8, 8'd2
    };

endpackage

// File: hw/rtl/binary_line_thinning.sv
// binary line thinning, template-based four-subpass thinning
//
// input channel (in_valid/in_ready): one request per image row; row_pixels bit c
// is column c, last_row marks the final row and starts thinning. rows past
// MAX_ROWS are dropped, their last_row mark still counts.
// output channel (out_valid/out_ready): one request per loaded row, top row first,
// with row_index, final_row on the last one, status and passes_done.
// config port: cfg_we writes cfg_wdata into register cfg_index
// (0 cols_in_use, 1 max_passes); write only while the block is idle.
//
// flow: a row that is not the last one is taken whenever the block is idle. after
// the last row the block scans the image (n = rows loaded), then runs passes of
// four subpasses, each subpass a priming step and a sweep over the n rows through
// the image memory (one write port, one registered read port) and the shared template unit.
// rows then leave one by one, each read once the output register is free.
// in_ready is low from the last row until the final result sits in the
// output register; a stalled receiver holds the block in its emit phase.
// reset: config returns to cols_in_use 64 and max_passes 20, the row count
// clears and the image memory content is left as is.
module binary_line_thinning #(
    parameter int ROW_WIDTH = blt_pkg::DEF_ROW_WIDTH,
    parameter int MAX_ROWS  = blt_pkg::DEF_MAX_ROWS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // config write port
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [6:0]           cfg_wdata,
    // row input
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [ROW_WIDTH-1:0] row_pixels,
    input  logic                 last_row,
    // thinned row output
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ROW_WIDTH-1:0] thinned_row,
    output logic [5:0]           row_index,
    output logic                 final_row,
    output logic [1:0]           status,
    output logic [5:0]           passes_done
);

    localparam int RW = ROW_WIDTH;
    localparam int AW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_ROWS + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_SCAN_END = 3'd2;
    localparam logic [2:0] S_PRIME    = 3'd3;
    localparam logic [2:0] S_PRIME2   = 3'd4;
    localparam logic [2:0] S_SWEEP    = 3'd5;
    localparam logic [2:0] S_EMIT_RD  = 3'd6;
    localparam logic [2:0] S_EMIT_LD  = 3'd7;

    // one template pair against the neighbour words
    function automatic logic [RW-1:0] tpl_match(input logic [7:0][RW-1:0] nb,
                                                input logic [2:0] t);
        logic [RW-1:0] m;
        m = '1;
        for (int k = 0; k < 8; k++)
        begin
            if (blt_pkg::HIT_TPL[t][k])
                m = m & nb[k];
            if (blt_pkg::MISS_TPL[t][k])
                m = m & ~nb[k];
        end
        return m;
    endfunction

    // image memory
    logic [RW-1:0] mem [MAX_ROWS];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [RW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [RW-1:0] rd_data_reg;

    // control and datapath registers
    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] r_reg, r_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] rows_loaded_reg, rows_loaded_next;
    logic [1:0]    sub_reg, sub_next;
    logic [5:0]    pass_cnt_reg, pass_cnt_next;
    logic          any_fg_reg, any_fg_next;
    logic          any_del_reg, any_del_next;
    logic [1:0]    status_reg, status_next;
    logic [RW-1:0] mask_reg, mask_next;
    logic [RW-1:0] above_reg, above_next;
    logic [RW-1:0] cur_reg, cur_next;
    logic [6:0]    cols_in_use_reg;
    logic [5:0]    max_passes_reg;

    // output register
    logic          out_valid_reg, out_valid_next;
    logic [RW-1:0] out_row_reg, out_row_next;
    logic [5:0]    out_index_reg, out_index_next;
    logic          out_final_reg, out_final_next;
    logic [1:0]    out_status_reg, out_status_next;
    logic [5:0]    out_passes_reg, out_passes_next;

    // shared template unit
    logic [RW-1:0]         width_mask;
    logic [RW-1:0]         rd_masked;
    logic [RW-1:0]         below;
    logic [7:0][RW-1:0]    nb;
    logic [RW-1:0]         del;
    logic                  row_has_below;
    logic                  row_is_last;
    logic                  in_fire;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign rd_masked = rd_data_reg & mask_reg;

    // width mask from the live register, latched when thinning starts
    always_comb
    begin
        for (int c = 0; c < RW; c++)
            width_mask[c] = (cols_in_use_reg > 7'(c));
    end

    assign row_has_below = (CW'(r_reg + CW'(1)) < n_reg);
    assign row_is_last   = (r_reg == CW'(n_reg - CW'(1)));
    assign below         = row_has_below ? rd_masked : '0;

    always_comb
    begin
        nb[0] = above_reg << 1;
        nb[1] = cur_reg << 1;
        nb[2] = below << 1;
        nb[3] = below;
        nb[4] = below >> 1;
        nb[5] = cur_reg >> 1;
        nb[6] = above_reg >> 1;
        nb[7] = above_reg;
        // subpass s+1 uses pairs s, (s+1) mod 4 and s+4
        del = cur_reg & (tpl_match(nb, {1'b0, sub_reg})
                       | tpl_match(nb, {1'b0, 2'(sub_reg + 2'd1)})
                       | tpl_match(nb, {1'b1, sub_reg}));
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        r_next           = r_reg;
        n_next           = n_reg;
        rows_loaded_next = rows_loaded_reg;
        sub_next         = sub_reg;
        pass_cnt_next    = pass_cnt_reg;
        any_fg_next      = any_fg_reg;
        any_del_next     = any_del_reg;
        status_next      = status_reg;
        mask_next        = mask_reg;
        above_next       = above_reg;
        cur_next         = cur_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_row_next     = out_row_reg;
        out_index_next   = out_index_reg;
        out_final_next   = out_final_reg;
        out_status_next  = out_status_reg;
        out_passes_next  = out_passes_reg;
        mem_we           = 1'b0;
        mem_waddr        = rows_loaded_reg[AW-1:0];
        mem_wdata        = row_pixels;
        mem_raddr        = r_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (rows_loaded_reg < CW'(MAX_ROWS))
                    begin
                        mem_we           = 1'b1;
                        rows_loaded_next = CW'(rows_loaded_reg + CW'(1));
                    end
                    if (last_row)
                    begin
                        n_next      = rows_loaded_next;
                        mask_next   = width_mask;
                        r_next      = '0;
                        any_fg_next = 1'b0;
                        state_next  = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // read row r, fold in the row read the cycle before
                if (r_reg != '0)
                    any_fg_next = any_fg_reg | (|rd_masked);
                if (row_is_last)
                    state_next = S_SCAN_END;
                else
                    r_next = CW'(r_reg + CW'(1));
            end
            S_SCAN_END:
            begin
                r_next        = '0;
                pass_cnt_next = '0;
                sub_next      = '0;
                any_del_next  = 1'b0;
                if (!(any_fg_reg | (|rd_masked)))
                begin
                    status_next = blt_pkg::STAT_EMPTY;
                    state_next  = S_EMIT_RD;
                end
                else if (max_passes_reg == '0)
                begin
                    status_next = blt_pkg::STAT_PASS_LIMIT;
                    state_next  = S_EMIT_RD;
                end
                else
                begin
                    pass_cnt_next = 6'd1;
                    state_next    = S_PRIME;
                end
            end
            S_PRIME:
            begin
                mem_raddr  = '0;
                above_next = '0;
                state_next = S_PRIME2;
            end
            S_PRIME2:
            begin
                cur_next   = rd_masked;
                mem_raddr  = AW'(1);
                r_next     = '0;
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                // row r with its neighbours as they stood before this subpass
                mem_we       = 1'b1;
                mem_waddr    = r_reg[AW-1:0];
                mem_wdata    = cur_reg & ~del;
                mem_raddr    = AW'(r_reg + CW'(2));
                above_next   = cur_reg;
                cur_next     = below;
                any_del_next = any_del_reg | (|del);
                if (row_is_last)
                begin
                    r_next = '0;
                    if (sub_reg != 2'd3)
                    begin
                        sub_next   = 2'(sub_reg + 2'd1);
                        state_next = S_PRIME;
                    end
                    else if (!any_del_next)
                    begin
                        status_next = blt_pkg::STAT_CONVERGED;
                        state_next  = S_EMIT_RD;
                    end
                    else if (pass_cnt_reg < max_passes_reg)
                    begin
                        pass_cnt_next = 6'(pass_cnt_reg + 6'd1);
                        sub_next      = '0;
                        any_del_next  = 1'b0;
                        state_next    = S_PRIME;
                    end
                    else
                    begin
                        status_next = blt_pkg::STAT_PASS_LIMIT;
                        state_next  = S_EMIT_RD;
                    end
                end
                else
                begin
                    r_next = CW'(r_reg + CW'(1));
                end
            end
            S_EMIT_RD:
            begin
                if (!out_valid_reg)
                    state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                out_valid_next  = 1'b1;
                out_row_next    = rd_masked;
                out_index_next  = 6'(r_reg);
                out_final_next  = row_is_last;
                out_status_next = status_reg;
                out_passes_next = pass_cnt_reg;
                if (row_is_last)
                begin
                    rows_loaded_next = '0;
                    state_next       = S_IDLE;
                end
                else
                begin
                    r_next     = CW'(r_reg + CW'(1));
                    state_next = S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // image memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            r_reg           <= '0;
            n_reg           <= '0;
            rows_loaded_reg <= '0;
            sub_reg         <= '0;
            pass_cnt_reg    <= '0;
            any_fg_reg      <= 1'b0;
            any_del_reg     <= 1'b0;
            status_reg      <= blt_pkg::STAT_CONVERGED;
            out_valid_reg   <= 1'b0;
            cols_in_use_reg <= blt_pkg::COLS_IN_USE_RST;
            max_passes_reg  <= blt_pkg::MAX_PASSES_RST;
        end
        else
        begin
            state_reg       <= state_next;
            r_reg           <= r_next;
            n_reg           <= n_next;
            rows_loaded_reg <= rows_loaded_next;
            sub_reg         <= sub_next;
            pass_cnt_reg    <= pass_cnt_next;
            any_fg_reg      <= any_fg_next;
            any_del_reg     <= any_del_next;
            status_reg      <= status_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    blt_pkg::CFG_COLS_IN_USE: cols_in_use_reg <= cfg_wdata;
                    blt_pkg::CFG_MAX_PASSES:  max_passes_reg  <= cfg_wdata[5:0];
                    default:                  ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mask_reg       <= mask_next;
        above_reg      <= above_next;
        cur_reg        <= cur_next;
        out_row_reg    <= out_row_next;
        out_index_reg  <= out_index_next;
        out_final_reg  <= out_final_next;
        out_status_reg <= out_status_next;
        out_passes_reg <= out_passes_next;
    end

    assign out_valid   = out_valid_reg;
    assign thinned_row = out_row_reg;
    assign row_index   = out_index_reg;
    assign final_row   = out_final_reg;
    assign status      = out_status_reg;
    assign passes_done = out_passes_reg;

    // the sweep never runs past the loaded rows
    a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SWEEP |-> r_reg < n_reg)
        else $error("sweep row beyond loaded rows");

    // a pass only runs within the pass limit
    a_pass_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PRIME || state_reg == S_SWEEP)
            |-> (pass_cnt_reg >= 6'd1 && pass_cnt_reg <= max_passes_reg))
        else $error("pass count outside limit");

    // a row is only loaded into a free output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT_LD |-> !out_valid_reg)
        else $error("output register overwritten");

    // the last row of an image starts the scan
    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_row |=> state_reg == S_SCAN && n_reg != '0)
        else $error("thinning did not start");

    a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rows_loaded_reg <= CW'(MAX_ROWS))
        else $error("row count overflow");

endmodule

// File: test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // one thinned row as it leaves the block
    typedef struct packed {
        logic [63:0] pix;
        logic [5:0]  idx;
        logic        fin;
        logic [1:0]  stat;
        logic [5:0]  npass;
    } thin_row_t;

    // one row of the directed table; cols/passes are written before the row
    // when set_cfg is high, want is used instead of the predictor when typed
    typedef struct packed {
        bit          set_cfg;
        bit [6:0]    cols;
        bit [6:0]    passes;
        bit [63:0]   pix;
        bit          lst;
        bit          typed;
        thin_row_t   want;
    } probe_t;

    localparam int        NUM_PROBES = 22;
    localparam thin_row_t NO_ROW     = '0;

    // hit/miss neighbour masks, pair t at index t
    // neighbour bits: 0 nw, 1 w, 2 sw, 3 s, 4 se, 5 e, 6 ne, 7 n
    localparam logic [0:7][7:0] HIT_SET  = {8'd40, 8'd10, 8'd130, 8'd160,
                                            8'd42, 8'd138, 8'd162, 8'd168};
    localparam logic [0:7][7:0] MISS_SET = {8'd131, 8'd224, 8'd56, 8'd14,
                                            8'd128, 8'd32, 8'd8, 8'd2};

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [6:0]  cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] row_pixels;
    logic        last_row;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] thinned_row;
    logic [5:0]  row_index;
    logic        final_row;
    logic [1:0]  status;
    logic [5:0]  passes_done;

    // predictor copy of the image memory, row count and registers
    logic [63:0] img_rows [64];
    int unsigned rows_held;
    logic [6:0]  cols_cfg;
    logic [5:0]  passes_cfg;

    thin_row_t   expected_rows [$];
    int unsigned mismatches;
    bit          calm;
    probe_t      probes [NUM_PROBES];

    binary_line_thinning dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .row_pixels  (row_pixels),
        .last_row    (last_row),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .thinned_row (thinned_row),
        .row_index   (row_index),
        .final_row   (final_row),
        .status      (status),
        .passes_done (passes_done)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // hard stop in case the block hangs
    initial
    begin
        #40ms;
        $display("status: fail");
        $finish;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // columns whose neighbourhood matches template pair t
    function automatic logic [63:0] tpl_hits(logic [7:0][63:0] nb, int t);
        logic [63:0] m;
        m = '1;
        for (int k = 0; k < 8; k++)
        begin
            if (HIT_SET[t][k])
                m &= nb[k];
            if (MISS_SET[t][k])
                m &= ~nb[k];
        end
        return m;
    endfunction

    // one subpass over n rows; every match is judged on the image before
    // the subpass, so the row above is kept as it was and the row below
    // is still untouched; returns whether anything was cleared
    function automatic bit run_subpass(int unsigned j, int unsigned n);
        logic [63:0]      above, cur, below, del;
        logic [7:0][63:0] nb;
        bit               cleared;
        above   = '0;
        cleared = 1'b0;
        for (int r = 0; r < n; r++)
        begin
            cur   = img_rows[r];
            below = (r + 1 < n) ? img_rows[r + 1] : '0;
            nb[0] = above << 1;
            nb[1] = cur << 1;
            nb[2] = below << 1;
            nb[3] = below;
            nb[4] = below >> 1;
            nb[5] = cur >> 1;
            nb[6] = above >> 1;
            nb[7] = above;
            del = cur & (tpl_hits(nb, j - 1) | tpl_hits(nb, j % 4) | tpl_hits(nb, j + 3));
            if (del != '0)
                cleared = 1'b1;
            above       = cur;
            img_rows[r] = cur & ~del;
        end
        return cleared;
    endfunction

    // mask to the image width, thin, and list the rows that come out
    task automatic thin_image(output thin_row_t res [$]);
        logic [63:0] mask, fg;
        int unsigned w, n, runs;
        logic [1:0]  verdict;
        bit          more;
        thin_row_t   one;
        n    = rows_held;
        w    = (cols_cfg > 7'd64) ? 64 : 32'(cols_cfg);
        mask = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
        fg   = '0;
        for (int r = 0; r < n; r++)
        begin
            img_rows[r] &= mask;
            fg |= img_rows[r];
        end
        runs = 0;
        if (fg == '0)
            verdict = blt_pkg::STAT_EMPTY;
        else
        begin
            // a zero pass limit leaves more set and reports the limit
            more = 1'b1;
            while (more && runs < passes_cfg)
            begin
                runs++;
                more = 1'b0;
                for (int j = 1; j <= 4; j++)
                    if (run_subpass(j, n))
                        more = 1'b1;
            end
            verdict = more ? blt_pkg::STAT_PASS_LIMIT : blt_pkg::STAT_CONVERGED;
        end
        res = {};
        for (int r = 0; r < n; r++)
        begin
            one.pix   = img_rows[r];
            one.idx   = 6'(r);
            one.fin   = (r + 1 == n);
            one.stat  = verdict;
            one.npass = 6'(runs);
            res.push_back(one);
        end
        rows_held = 0;
    endtask

    // predictor update for one accepted row request; rows past the
    // memory depth are dropped but their last mark still counts
    task automatic take_row(logic [63:0] pix, logic lst, bit typed, thin_row_t want);
        thin_row_t res [$];
        if (rows_held < 64)
        begin
            img_rows[rows_held] = pix;
            rows_held++;
        end
        if (lst)
        begin
            thin_image(res);
            if (typed)
                expected_rows.push_back(want);
            else
                foreach (res[i])
                    expected_rows.push_back(res[i]);
        end
    endtask

    // single-row image result typed into the table
    function automatic thin_row_t solo(logic [63:0] pix, logic [1:0] stat, logic [5:0] npass);
        thin_row_t t;
        t.pix   = pix;
        t.idx   = 6'd0;
        t.fin   = 1'b1;
        t.stat  = stat;
        t.npass = npass;
        return t;
    endfunction

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // idle length: mostly short, now and then long
    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(15, 60);
        return $urandom_range(1, 3);
    endfunction

    // present one row request, hold it until taken; with no gap valid stays
    // high and only the payload moves on to the next row
    task automatic send_row(logic [63:0] pix, logic lst, int gap, bit typed, thin_row_t want);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        row_pixels <= pix;
        last_row   <= lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        take_row(pix, lst, typed, want);
    endtask

    // drop valid and hold off until every expected row has come out, then
    // wait on so that the block can go quiet
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic cfg_write(logic idx, logic [6:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == blt_pkg::CFG_COLS_IN_USE)
            cols_cfg = data;
        else
            passes_cfg = data[5:0];
    endtask

    // receiver: random stalls unless in a calm stretch
    initial
    begin : drain
        int stall;
        stall     = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall = idle_len();
            end
        end
    end

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------

    task automatic flag_field(string what, logic [63:0] want, logic [63:0] got);
        if (mismatches < 10)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : watch
        thin_row_t got, want;
        if (rst_n && out_valid && out_ready)
        begin
            got.pix   = thinned_row;
            got.idx   = row_index;
            got.fin   = final_row;
            got.stat  = status;
            got.npass = passes_done;
            if (expected_rows.size() == 0)
            begin
                if (mismatches < 10)
                    $display("row result with none expected: row %0d, %h", row_index,
                             thinned_row);
                mismatches++;
            end
            else
            begin
                want = expected_rows.pop_front();
                if (got.pix !== want.pix)
                    flag_field("thinned_row", want.pix, got.pix);
                if (got.idx !== want.idx)
                    flag_field("row_index", 64'(want.idx), 64'(got.idx));
                if (got.fin !== want.fin)
                    flag_field("final_row", 64'(want.fin), 64'(got.fin));
                if (got.stat !== want.stat)
                    flag_field("status", 64'(want.stat), 64'(got.stat));
                if (got.npass !== want.npass)
                    flag_field("passes_done", 64'(want.npass), 64'(got.npass));
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    initial
    begin : stimulus
        int          rows_sent, images, height, mode, r;
        int          lo, w, slope, bar_lo, bar_h, bar_start, bar_len;
        logic [6:0]  cols_pick, passes_pick;
        logic [63:0] pix;

        cfg_we     = 1'b0;
        cfg_index  = blt_pkg::CFG_COLS_IN_USE;
        cfg_wdata  = '0;
        in_valid   = 1'b0;
        row_pixels = '0;
        last_row   = 1'b0;
        rst_n      = 1'b0;
        mismatches = 0;
        calm       = 1'b0;
        rows_held  = 0;
        cols_cfg   = blt_pkg::COLS_IN_USE_RST;
        passes_cfg = blt_pkg::MAX_PASSES_RST;

        // directed rows: extremes, register corners and the special cases
        probes = '{
            // reset defaults, empty one-row image
            '{1'b0, 7'd0, 7'd0, 64'h0, 1'b1, 1'b1, solo(64'h0, blt_pkg::STAT_EMPTY, 6'd0)},
            // lone pixels at both row ends survive a single pass
            '{1'b0, 7'd0, 7'd0, 64'h1, 1'b1, 1'b1,
              solo(64'h1, blt_pkg::STAT_CONVERGED, 6'd1)},
            '{1'b0, 7'd0, 7'd0, 64'h8000_0000_0000_0000, 1'b1, 1'b1,
              solo(64'h8000_0000_0000_0000, blt_pkg::STAT_CONVERGED, 6'd1)},
            // solid three-row block
            '{1'b0, 7'd0, 7'd0, '1, 1'b0, 1'b0, NO_ROW},
            '{1'b0, 7'd0, 7'd0, '1, 1'b0, 1'b0, NO_ROW},
            '{1'b0, 7'd0, 7'd0, '1, 1'b1, 1'b0, NO_ROW},
            // zero width clears every pixel
            '{1'b1, 7'd0, 7'd20, '1, 1'b1, 1'b1, solo(64'h0, blt_pkg::STAT_EMPTY, 6'd0)},
            // one column left, converged on the last allowed pass
            '{1'b1, 7'd1, 7'd1, '1, 1'b1, 1'b1,
              solo(64'h1, blt_pkg::STAT_CONVERGED, 6'd1)},
            // oversized width, zero pass limit
            '{1'b1, 7'd127, 7'd0, 64'hFF00, 1'b1, 1'b1,
              solo(64'hFF00, blt_pkg::STAT_PASS_LIMIT, 6'd0)},
            // zero pass limit on an empty image still reports empty
            '{1'b0, 7'd0, 7'd0, 64'h0, 1'b1, 1'b1, solo(64'h0, blt_pkg::STAT_EMPTY, 6'd0)},
            // thick bars with a single pass
            '{1'b1, 7'd64, 7'd1, 64'h0000_0FF0_0000_0000, 1'b0, 1'b0, NO_ROW},
            '{1'b0, 7'd0, 7'd0, 64'h0000_0FF0_0000_0FF0, 1'b0, 1'b0, NO_ROW},
            '{1'b0, 7'd0, 7'd0, 64'h0000_0FF0_0000_0FF0, 1'b0, 1'b0, NO_ROW},
            '{1'b0, 7'd0, 7'd0, 64'h0000_0FF0_0000_0000, 1'b1, 1'b0, NO_ROW},
            // busy patterns with the widest pass limit
            '{1'b1, 7'd64, 7'd63, 64'h5555_5555_5555_5555, 1'b0, 1'b0, NO_ROW},
            '{1'b0, 7'd0, 7'd0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, NO_ROW},
            '{1'b0, 7'd0, 7'd0, '1, 1'b0, 1'b0, NO_ROW},
            '{1'b0, 7'd0, 7'd0, 64'h0F0F_0F0F_0F0F_0F0F, 1'b0, 1'b0, NO_ROW},
            '{1'b0, 7'd0, 7'd0, 64'hFFFF_0000_FFFF_0000, 1'b1, 1'b0, NO_ROW},
            // narrow image, pass limit written with the top bit set
            '{1'b1, 7'd8, 7'd66, '1, 1'b0, 1'b0, NO_ROW},
            '{1'b0, 7'd0, 7'd0, '1, 1'b0, 1'b0, NO_ROW},
            '{1'b0, 7'd0, 7'd0, '1, 1'b1, 1'b0, NO_ROW}
        };

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (probes[i])
        begin
            // registers only change with the block idle
            if (probes[i].set_cfg)
            begin
                settle();
                cfg_write(blt_pkg::CFG_COLS_IN_USE, probes[i].cols);
                cfg_write(blt_pkg::CFG_MAX_PASSES, probes[i].passes);
            end
            send_row(probes[i].pix, probes[i].lst, $urandom_range(0, 2), probes[i].typed,
                     probes[i].want);
        end

        // random images: strokes that thinning has real work on, plus noise
        rows_sent = 0;
        images    = 0;
        while (rows_sent < 300)
        begin
            calm = ($urandom_range(0, 5) == 0);

            // new register setting between images now and then; the sender
            // waits for every pending row first
            if (images == 0 || $urandom_range(0, 3) == 0)
            begin
                settle();
                case ($urandom_range(0, 9))
                    0: cols_pick = 7'($urandom_range(65, 127));
                    1: cols_pick = 7'($urandom_range(1, 2));
                    2: cols_pick = 7'd64;
                    default: cols_pick = 7'($urandom_range(3, 63));
                endcase
                case ($urandom_range(0, 9))
                    0: passes_pick = 7'd63;
                    1: passes_pick = 7'd1;
                    2: passes_pick = 7'(64 + $urandom_range(1, 10));
                    default: passes_pick = 7'($urandom_range(2, 12));
                endcase
                cfg_write(blt_pkg::CFG_COLS_IN_USE, cols_pick);
                cfg_write(blt_pkg::CFG_MAX_PASSES, passes_pick);
            end

            // mostly short images, a few near or past full, one forced to overfill the store
            if (images == 2)
                height = 70;
            else if ($urandom_range(0, 11) == 0)
                height = $urandom_range(60, 68);
            else
                height = $urandom_range(1, 10);

            mode      = $urandom_range(0, 4);
            w         = $urandom_range(2, 10);
            lo        = $urandom_range(0, 53);
            slope     = $urandom_range(0, 2);
            bar_lo    = $urandom_range(0, height - 1);
            bar_h     = $urandom_range(2, 5);
            bar_len   = $urandom_range(4, 30);
            bar_start = $urandom_range(0, 64 - bar_len);

            for (r = 0; r < height; r++)
            begin
                case (mode)
                    0: pix = {$urandom, $urandom};
                    1: pix = {$urandom, $urandom} & {$urandom, $urandom};
                    2: pix = {$urandom, $urandom} | {$urandom, $urandom};
                    default:
                    begin
                        // thick slanted stroke crossed by a thick bar
                        pix = ((64'd1 << w) - 64'd1) << ((lo + r * slope) % (64 - w));
                        if (r >= bar_lo && r < bar_lo + bar_h)
                            pix |= ((64'd1 << bar_len) - 64'd1) << bar_start;
                    end
                endcase
                send_row(pix, r == height - 1,
                         (!calm && $urandom_range(0, 2) == 0) ? idle_len() : 0, 1'b0, NO_ROW);
                rows_sent++;
            end
            images++;
        end

        // drain and let the block settle before the verdict
        settle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_rows.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
